>>> design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, codes and control types for the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int MAX_PAGES_DEF  = 16384;
  localparam int COUNT_BITS_DEF = 16;

  // item field widths
  localparam int MODE_W      = 3;
  localparam int PAGE_W      = 14;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 16;
  localparam int FREE_W      = 15;
  localparam int IN_W        = 24;   // mode + page, padded to bytes
  localparam int OUT_W       = 48;   // page_out + status + count_after + free_pages

  // config port
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 15'd16384;

  typedef enum logic [MODE_W-1:0] {
    MODE_REBUILD = 3'd0,
    MODE_ALLOC   = 3'd1,
    MODE_FREE    = 3'd2,
    MODE_INC     = 3'd3,
    MODE_DEC     = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NO_FREE  = 3'd1,
    STS_REF_HELD = 3'd2,
    STS_RANGE    = 3'd3,
    STS_BAD      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_COUNT = 1'd0,
    CFG_RESERVED   = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_EXEC,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // latch item, launch memory reads
    logic sweep_step;   // one page of the clear/rebuild walk
    logic sweep_clear;  // walk writes all-zero entries, no pushes
    logic commit;       // write back the read-modify-write, load result
    logic respond;      // load a result that needs no memory access
  } pfa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic build;        // offered item is a rebuild
    logic imm;          // offered item is answered without memory access
    logic sweep_last;   // walk is on its last page
    logic out_free;     // result register can take a new result
  } pfa_stat_t;

endpackage

`default_nettype wire

>>> design/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: clear walk after reset, item accept, rebuild walk, write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl import pfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  pfa_stat_t stat,
  output pfa_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          if (stat.build)    state_next = S_SWEEP;
          else if (stat.imm) state_next = S_RESP;
          else               state_next = S_EXEC;
        end
      end
      S_SWEEP: begin
        if (stat.sweep_last) state_next = S_RESP;
      end
      S_EXEC, S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = (state == S_IDLE);
    cmd.accept      = (state == S_IDLE) && s_tvalid;
    cmd.sweep_step  = (state == S_CLEAR) || (state == S_SWEEP);
    cmd.sweep_clear = (state == S_CLEAR);
    cmd.commit      = (state == S_EXEC) && stat.out_free;
    cmd.respond     = (state == S_RESP) && stat.out_free;
  end

endmodule

`default_nettype wire

>>> design/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: config registers, free stack and count memories, stack depth,
// walk counter, read-modify-write logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_dp import pfa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  input  pfa_cmd_t             cmd,
  output pfa_stat_t            stat
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NW = $clog2(MAX_PAGES + 1);
  localparam int WW = (NW > CFG_W) ? NW : CFG_W;
  localparam int MW = COUNT_BITS + 1;   // {free bit, count}
  localparam logic [WW-1:0] MAXP_W = WW'(MAX_PAGES);
  localparam logic [NW-1:0] MAXP_N = NW'(MAX_PAGES);
  localparam logic [AW-1:0] LAST_PAGE = AW'(MAX_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [COUNT_BITS-1:0] CONE = COUNT_BITS'(1);

  // ---- config ----
  logic [CFG_W-1:0] page_count, reserved_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count     <= PAGE_COUNT_RST;
      reserved_pages <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_PAGE_COUNT: page_count     <= cfg_wdata;
        CFG_RESERVED:   reserved_pages <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] pc_w, rp_w, pool_n, pool_res;
  assign pc_w     = WW'(page_count);
  assign rp_w     = WW'(reserved_pages);
  assign pool_n   = (pc_w > MAXP_W) ? MAXP_W : pc_w;
  assign pool_res = (rp_w > pool_n) ? pool_n : rp_w;

  // ---- offered item decode ----
  logic [MODE_W-1:0] in_mode;
  logic [PAGE_W-1:0] in_page;
  logic              in_bad;
  logic [NW-1:0]     depth;
  logic              stack_empty, stack_full;

  assign in_mode     = s_tdata[MODE_W-1:0];
  assign in_page     = s_tdata[MODE_W +: PAGE_W];
  assign in_bad      = (in_mode > MODE_DEC) || (WW'(in_page) >= pool_n);
  assign stack_empty = (depth == '0);
  assign stack_full  = (depth == MAXP_N);

  // ---- latched item ----
  logic [MODE_W-1:0] lmode;
  logic [PAGE_W-1:0] lpage;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lmode <= in_mode;
      lpage <= in_page;
    end
  end

  // ---- walk counter ----
  logic [AW-1:0] sweep_cnt;
  logic [WW-1:0] sweep_w;
  logic          sw_in_res, sw_push;

  assign sweep_w   = WW'(sweep_cnt);
  assign sw_in_res = !cmd.sweep_clear && (sweep_w < pool_res);
  assign sw_push   = !cmd.sweep_clear && !(sweep_w < pool_res) && (sweep_w < pool_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt <= (sweep_cnt == LAST_PAGE) ? '0 : sweep_cnt + AW'(1);
    end
  end

  // ---- memories ----
  logic          stack_we, meta_we;
  logic [AW-1:0] stack_waddr, stack_wdata, stack_raddr, stack_q;
  logic [AW-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0] meta_wdata, meta_q;

  assign stack_raddr = AW'(depth - NW'(1));
  assign meta_raddr  = AW'(in_page);

  pfa_ram #(.WIDTH(AW), .DEPTH(MAX_PAGES)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (cmd.accept),
    .raddr (stack_raddr),
    .rdata (stack_q)
  );

  pfa_ram #(.WIDTH(MW), .DEPTH(MAX_PAGES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (cmd.accept),
    .raddr (meta_raddr),
    .rdata (meta_q)
  );

  // ---- read-modify-write ----
  logic                  mf;
  logic [COUNT_BITS-1:0] mc, dec_c;
  status_t               ex_status;
  logic [COUNT_BITS-1:0] ex_count;
  logic [AW-1:0]         ex_page;
  logic                  ex_push, ex_mwe;
  logic [MW-1:0]         ex_mwdata;
  logic [NW-1:0]         ex_depth;

  assign mf    = meta_q[COUNT_BITS];
  assign mc    = meta_q[COUNT_BITS-1:0];
  assign dec_c = mc - CONE;

  always_comb begin
    ex_status = STS_OK;
    ex_count  = '0;
    ex_page   = AW'(lpage);
    ex_push   = 1'b0;
    ex_mwe    = 1'b0;
    ex_mwdata = meta_q;
    ex_depth  = depth;
    case (lmode)
      MODE_ALLOC: begin
        ex_page   = stack_q;
        ex_count  = CONE;
        ex_mwe    = 1'b1;
        ex_mwdata = {1'b0, CONE};
        ex_depth  = depth - NW'(1);
      end
      MODE_FREE: begin
        if (mf) begin
          ex_status = STS_BAD;
        end else if (mc != '0) begin
          ex_status = STS_REF_HELD;
          ex_count  = mc;
        end else if (!stack_full) begin
          ex_push   = 1'b1;
          ex_mwe    = 1'b1;
          ex_mwdata = {1'b1, mc};
          ex_depth  = depth + NW'(1);
        end
      end
      MODE_INC: begin
        if (mf) begin
          ex_status = STS_BAD;
        end else if (mc == CMAX) begin
          ex_status = STS_RANGE;
          ex_count  = CMAX;
        end else begin
          ex_count  = mc + CONE;
          ex_mwe    = 1'b1;
          ex_mwdata = {mf, mc + CONE};
        end
      end
      default: begin  // decrement
        if (mc == '0) begin
          ex_status = STS_RANGE;
        end else begin
          ex_count  = dec_c;
          ex_mwe    = 1'b1;
          // reaching zero while in use returns the page to the stack
          if (dec_c == '0 && !mf && !stack_full) begin
            ex_push   = 1'b1;
            ex_mwdata = {1'b1, dec_c};
            ex_depth  = depth + NW'(1);
          end else begin
            ex_mwdata = {mf, dec_c};
          end
        end
      end
    endcase
  end

  // write port muxes: walk has priority (never overlaps a commit)
  always_comb begin
    if (cmd.sweep_step) begin
      meta_we     = 1'b1;
      meta_waddr  = sweep_cnt;
      meta_wdata  = {sw_push, sw_in_res ? CONE : '0};
      stack_we    = sw_push;
      stack_waddr = AW'(depth);
      stack_wdata = sweep_cnt;
    end else begin
      meta_we     = cmd.commit && ex_mwe;
      meta_waddr  = ex_page;
      meta_wdata  = ex_mwdata;
      stack_we    = cmd.commit && ex_push;
      stack_waddr = AW'(depth);
      stack_wdata = AW'(lpage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.accept && (in_mode == MODE_REBUILD)) begin
      depth <= '0;
    end else if (cmd.sweep_step && sw_push) begin
      depth <= depth + NW'(1);
    end else if (cmd.commit) begin
      depth <= ex_depth;
    end
  end

  // ---- result register ----
  logic [PAGE_W-1:0] im_page;
  status_t           im_status;

  always_comb begin
    case (lmode)
      MODE_REBUILD: begin
        im_page   = '0;
        im_status = STS_OK;
      end
      MODE_ALLOC: begin
        im_page   = '0;
        im_status = STS_NO_FREE;
      end
      default: begin
        im_page   = lpage;
        im_status = STS_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit || cmd.respond) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {FREE_W'(ex_depth), COUNT_OUT_W'(ex_count), ex_status, PAGE_W'(ex_page)};
    end else if (cmd.respond) begin
      m_tdata <= {FREE_W'(depth), COUNT_OUT_W'(0), im_status, im_page};
    end
  end

  // ---- status to controller ----
  assign stat.build      = (in_mode == MODE_REBUILD);
  assign stat.imm        = (in_mode == MODE_ALLOC) ? stack_empty : in_bad;
  assign stat.sweep_last = (sweep_cnt == LAST_PAGE);
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

>>> design/page_frame_allocator_refcount.sv
// Allocate, free, increment, decrement: accepted (memory reads launched), then
//   memory read-modify-write, written back once the result register can take it.
// One item in flight: a new request is accepted only once the last is answered.
// Rebuild walks every page before its result.
// Reset: synchronous; a clearing walk over all MAX_PAGES pages zeroes all counts
//   and free bits, s_tready stays low during it. Stack depth resets to 0.
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame pool with per-page reference counts and a LIFO free stack.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_refcount import pfa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write port: index 0 page_count, index 1 reserved_pages
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // [2:0] mode, [16:3] page, rest zero
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // [13:0] page_out, [16:14] status,
                                          // [32:17] count_after, [47:33] free_pages
);

  // The controller sequences the clear walk, accept, rebuild walk and the
  // write-back; the datapath holds both RAMs (free stack and {free, count}
  // per page), the stack depth and the result register. A finished result
  // waits in the result register while the next item is accepted; the
  // write-back of that next item waits only if the register is still full.
  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

>>> design/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks for the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker import pfa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [STATUS_W-1:0]    sts;
  logic [COUNT_OUT_W-1:0] cnt;
  logic [FREE_W-1:0]      nfree;
  logic [PAGE_W-1:0]      pg;

  assign pg    = m_tdata[PAGE_W-1:0];
  assign sts   = m_tdata[PAGE_W +: STATUS_W];
  assign cnt   = m_tdata[PAGE_W + STATUS_W +: COUNT_OUT_W];
  assign nfree = m_tdata[PAGE_W + STATUS_W + COUNT_OUT_W +: FREE_W];

  // one item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("accept directly after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_no_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sts == STS_NO_FREE) |-> (nfree == '0 && cnt == '0 && pg == '0))
    else $error("empty-stack result inconsistent");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sts == STS_BAD) |-> (cnt == '0))
    else $error("rejected item reports a count");

  // clearing walk follows reset: nothing in or out
  a_reset: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("handshake active after reset");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (.*);

`default_nettype wire

>>> test/page_frame_allocator_refcount_test.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_test
// Self-checking bench for the page frame pool. Request items are queued by a
// sequencer and driven through a stream driver. Each accepted request runs
// through a local pool model that predicts the result item. A monitor
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_test;
  import pfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAGES   = MAX_PAGES_DEF;
  localparam int unsigned HOT_SPAN    = 16;       // width of the busy page windows
  localparam int unsigned HOLD_CYCLES = 500;      // long result backpressure
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  localparam logic [COUNT_OUT_W-1:0] REF_LIMIT = '1;  // saturated count
  localparam logic [MODE_W-1:0]      MODE_TOP  = '1;  // highest mode code
  localparam logic [PAGE_W-1:0]      PAGE_TOP  = '1;  // highest page number

  // request item, lowest bits first: mode, page, zero pad
  typedef struct packed {
    logic [IN_W-PAGE_W-MODE_W-1:0] pad;
    logic [PAGE_W-1:0]             page;
    logic [MODE_W-1:0]             mode;
  } frame_req_t;

  // result item, lowest bits first: page_out, status, count_after, free_pages
  typedef struct packed {
    logic [FREE_W-1:0]      free_pages;
    logic [COUNT_OUT_W-1:0] count_after;
    logic [STATUS_W-1:0]    status;
    logic [PAGE_W-1:0]      page_out;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_idx = CFG_PAGE_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // [2:0] mode, [16:3] page, rest zero
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // [13:0] page_out, [16:14] status,
                                    // [32:17] count_after, [47:33] free_pages

  page_frame_allocator_refcount i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pool model: counts, free bits and the free stack, plus the two registers.
  // --------------------------------------------------------------------------
  logic [COUNT_OUT_W-1:0] frame_refs     [MAX_PAGES];
  bit                     frame_on_stack [MAX_PAGES];
  logic [PAGE_W-1:0]      free_frames    [MAX_PAGES];
  int unsigned            free_depth;
  int unsigned            pool_pages;
  int unsigned            pool_reserved;

  frame_req_t    pending_reqs[$];   // requests not yet offered
  frame_result_t owed_results[$];   // predictions waiting for their result item

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;        // bumped by the sequencer to ask for a holdoff
  int unsigned hold_done;
  int unsigned hold_left;
  int unsigned faults = 0;
  int unsigned cycle_count = 0;
  frame_result_t got_res, want_res;

  // a push at full depth is dropped; distinct free bits keep that from happening
  function automatic void push_frame(input int unsigned pg);
    if (free_depth < MAX_PAGES) begin
      free_frames[free_depth] = pg[PAGE_W-1:0];
      free_depth++;
      frame_on_stack[pg] = 1'b1;
    end
  endfunction

  function automatic frame_result_t serve_request(input frame_req_t rq);
    frame_result_t res;
    int unsigned pool, held, i;
    logic [PAGE_W-1:0] pg;
    pool = (pool_pages > MAX_PAGES) ? MAX_PAGES : pool_pages;
    pg = rq.page;
    res = '0;
    res.page_out = pg;
    if (rq.mode == MODE_REBUILD) begin
      // reserved pages start in use; the rest go on the stack lowest first,
      // so the highest page pops first
      held = (pool_reserved > pool) ? pool : pool_reserved;
      free_depth = 0;
      for (i = 0; i < MAX_PAGES; i++) begin
        frame_on_stack[i] = 1'b0;
        frame_refs[i] = (i < held) ? 1 : 0;
        if (i >= held && i < pool)
          push_frame(i);
      end
      res.page_out = '0;
    end else if (rq.mode == MODE_ALLOC) begin
      if (free_depth == 0) begin
        res.page_out = '0;
        res.status = STS_NO_FREE;
      end else begin
        // pop does not look at the pool size: a shrunk pool may hand out a high page
        free_depth--;
        pg = free_frames[free_depth];
        frame_on_stack[pg] = 1'b0;
        frame_refs[pg] = 1;
        res.page_out = pg;
        res.count_after = 1;
      end
    end else if (rq.mode > MODE_DEC || pg >= pool) begin
      res.status = STS_BAD;
    end else if (rq.mode == MODE_FREE) begin
      if (frame_on_stack[pg])
        res.status = STS_BAD;
      else if (frame_refs[pg] != 0) begin
        res.status = STS_REF_HELD;
        res.count_after = frame_refs[pg];
      end else
        push_frame(pg);
    end else if (rq.mode == MODE_INC) begin
      if (frame_on_stack[pg])
        res.status = STS_BAD;
      else if (frame_refs[pg] == REF_LIMIT) begin
        res.status = STS_RANGE;
        res.count_after = REF_LIMIT;
      end else begin
        frame_refs[pg]++;
        res.count_after = frame_refs[pg];
      end
    end else begin
      if (frame_refs[pg] == 0)
        res.status = STS_RANGE;
      else begin
        frame_refs[pg]--;
        if (frame_refs[pg] == 0 && !frame_on_stack[pg])
          push_frame(pg);
        res.count_after = frame_refs[pg];
      end
    end
    res.free_pages = free_depth[FREE_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, predicts on acceptance, tracks reg writes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      free_depth = 0;
      pool_pages = PAGE_COUNT_RST;
      pool_reserved = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_PAGE_COUNT)
          pool_pages = cfg_wdata;
        else
          pool_reserved = cfg_wdata;
      end
      if (s_tvalid && s_tready)
        owed_results.push_back(serve_request(s_tdata));
      // a held item stays put until taken
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= pending_reqs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, long holdoffs on request, field checks.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_done <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = m_tdata;
        if (owed_results.size() == 0) begin
          $error("result item with nothing expected: %h", m_tdata);
          faults++;
        end else begin
          want_res = owed_results.pop_front();
          if (got_res.page_out !== want_res.page_out) begin
            $error("page_out: expected %0d, got %0d", want_res.page_out, got_res.page_out);
            faults++;
          end
          if (got_res.status !== want_res.status) begin
            $error("status: expected %0d, got %0d", want_res.status, got_res.status);
            faults++;
          end
          if (got_res.count_after !== want_res.count_after) begin
            $error("count_after: expected %0d, got %0d",
                   want_res.count_after, got_res.count_after);
            faults++;
          end
          if (got_res.free_pages !== want_res.free_pages) begin
            $error("free_pages: expected %0d, got %0d",
                   want_res.free_pages, got_res.free_pages);
            faults++;
          end
        end
      end
      if (hold_done != hold_req) begin
        hold_done <= hold_done + 1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("page_frame_allocator_refcount verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  int unsigned phase_pool = 1;

  function automatic void offer(input logic [MODE_W-1:0] mode, input int unsigned page);
    frame_req_t rq;
    rq = '0;
    rq.mode = mode;
    rq.page = page[PAGE_W-1:0];
    pending_reqs.push_back(rq);
  endfunction

  // Busy pages cluster at the top of the pool (they pop first after a rebuild)
  // and at the bottom (reserved pages); some picks go anywhere in the pool or
  // anywhere in the page field.
  function automatic void offer_random(input int unsigned count);
    int unsigned k, roll, span;
    logic [MODE_W-1:0] mode;
    int unsigned pg;
    span = (phase_pool < HOT_SPAN) ? phase_pool : HOT_SPAN;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 22)      mode = MODE_ALLOC;
      else if (roll < 40) mode = MODE_FREE;
      else if (roll < 68) mode = MODE_INC;
      else if (roll < 97) mode = MODE_DEC;
      else                mode = MODE_W'($urandom_range(MODE_DEC + 1, MODE_TOP));
      roll = $urandom_range(99);
      if (roll < 45)      pg = phase_pool - 1 - $urandom_range(0, span - 1);
      else if (roll < 65) pg = $urandom_range(0, span - 1);
      else if (roll < 88) pg = $urandom_range(0, phase_pool - 1);
      else                pg = $urandom_range(0, PAGE_TOP);
      offer(mode, pg);
    end
  endfunction

  // every request has exactly one result, so an empty prediction queue with
  // nothing offered means the block is idle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || owed_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain, reprogram, optionally rebuild; the caller then queues the items
  task automatic start_phase(input int unsigned pages, input int unsigned reserved,
                             input bit rebuild);
    wait_drained();
    write_reg(CFG_PAGE_COUNT, pages);
    write_reg(CFG_RESERVED, reserved);
    @(negedge clk);
    phase_pool = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    if (rebuild)
      offer(MODE_REBUILD, 0);
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    int unsigned m;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_idle(29, 63);

    // directed: 4-page pool, page 0 reserved -> stack holds 1, 2, 3
    start_phase(4, 1, 1'b1);
    offer(MODE_ALLOC, 0);          // pops 3
    offer(MODE_ALLOC, 0);          // pops 2
    offer(MODE_ALLOC, 0);          // pops 1
    offer(MODE_ALLOC, 0);          // empty stack
    offer(MODE_FREE, 0);           // still referenced
    offer(MODE_INC, 0);
    offer(MODE_DEC, 0);
    offer(MODE_DEC, 0);            // reaches zero, pushed
    offer(MODE_FREE, 0);           // already free
    offer(MODE_INC, 0);            // increment of a free page
    offer(MODE_DEC, 0);            // decrement at zero
    offer(MODE_FREE, 4);           // bad page, just past the pool
    offer(MODE_INC, PAGE_TOP);     // bad page, top of the field
    offer(MODE_DEC, 4);
    for (m = MODE_DEC + 1; m <= MODE_TOP; m++)
      offer(MODE_W'(m), (m == MODE_TOP) ? PAGE_TOP : 'h2AAA);   // bad modes
    offer(MODE_ALLOC, 0);          // pops 0
    offer(MODE_FREE, 3);           // still referenced

    // grow the pool without a rebuild: pages 4..7 are in use with count zero
    start_phase(8, 1, 1'b0);
    offer(MODE_FREE, 6);           // plain free
    offer(MODE_INC, 5);
    offer(MODE_DEC, 5);            // back to zero, pushed
    offer(MODE_ALLOC, 0);
    offer(MODE_ALLOC, 0);

    // random phases, sender idle light, receiver idle heavy
    start_phase(MAX_PAGES, 0, 1'b1);
    offer_random(300);
    start_phase(1, 0, 1'b1);
    offer_random(150);
    start_phase(37, 5, 1'b1);
    offer_random(200);

    set_idle(63, 29);
    start_phase(MAX_PAGES, MAX_PAGES, 1'b1);   // everything reserved
    offer_random(150);
    start_phase(200, 300, 1'b1);               // reserve beyond the pool
    offer_random(150);
    start_phase(1000, 300, 1'b0);              // grow without rebuild
    offer_random(200);
    start_phase(20, 19, 1'b1);
    offer_random(150);
    start_phase(10, 19, 1'b0);                 // shrink: the stack can still hold page 19
    offer_random(100);

    set_idle(0, 0);
    start_phase(MAX_PAGES, 100, 1'b1);
    offer_random(150);
    // result side blocks for a while; the input side backs up behind it
    start_phase(MAX_PAGES, 100, 1'b0);
    offer_random(200);
    hold_req++;
    start_phase(64, 0, 1'b1);
    offer_random(200);

    wait_drained();
    repeat (8) @(negedge clk);
    if (faults == 0 && owed_results.size() == 0)
      $display("page_frame_allocator_refcount verification clean");
    else
      $display("page_frame_allocator_refcount verification failed");
    $finish;
  end

endmodule
